FILE: hdl/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg
// Types, codes and slot helpers shared by the bag matching transition block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmt_pkg;

    localparam int SLOTS  = 15;
    localparam int SLOT_W = 4;
    localparam int SOL_W  = SLOTS * SLOT_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef slot_t [SLOTS-1:0] sol_t;

    // saturated-slot marker: both edges of the vertex are in use
    localparam slot_t TWO = 4'd15;

    typedef enum logic [1:0] {
        OP_ADD_VERTEX = 2'd0,
        OP_ADD_EDGE   = 2'd1,
        OP_DEL_VERTEX = 2'd2,
        OP_JOIN       = 2'd3
    } op_t;

    // one classified item as held in the queue
    typedef struct packed {
        op_t   op;
        sol_t  slots;
        sol_t  base;
        slot_t va;
        slot_t vb;
        slot_t cnt;
        logic  mark;
        logic  may_close;
    } item_t;

    // read a slot; positions at or above the limit read as zero
    function automatic slot_t slot_rd(sol_t m, slot_t idx, slot_t lim);
        return (idx < lim) ? m[idx] : '0;
    endfunction

    // write a slot; positions at or above the limit are dropped
    function automatic sol_t slot_wr(sol_t m, slot_t idx, slot_t val, slot_t lim);
        sol_t r;
        r = m;
        if (idx < lim)
            r[idx] = val;
        return r;
    endfunction

    // join two path ends v and w
    function automatic sol_t slot_link(sol_t m, slot_t v, slot_t w, slot_t lim);
        sol_t  r;
        slot_t vm;
        slot_t wm;
        vm = slot_rd(m, v, lim);
        wm = slot_rd(m, w, lim);
        r  = m;
        if (vm != v)
            r = slot_wr(r, v, TWO, lim);
        if (wm != w)
            r = slot_wr(r, w, TWO, lim);
        r = slot_wr(r, vm, wm, lim);
        r = slot_wr(r, wm, vm, lim);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bmt_front.sv
// ----------------------------------------------------------------------------
// bmt_front
// Accepts items, masks absent slots, classifies the edge close condition and
// queues the item for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_front #(
    parameter int MAX_SLOTS = 15
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mode,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [59:0]        slots,
    input  wire logic [59:0]        base_slots,
    input  wire logic [3:0]         vertex_a,
    input  wire logic [3:0]         vertex_b,
    input  wire logic [3:0]         bag_count,
    input  wire logic               closing_edge,
    input  wire logic               edge_marked,
    output logic                    q_valid,
    output bmt_pkg::item_t          q_item,
    input  wire logic               q_pop
);

    bmt_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    bmt_pkg::item_t item_in;
    logic           push;

    // mask slots beyond the configured bag capacity
    always_comb
    begin
        item_in.op        = bmt_pkg::op_t'(op);
        item_in.slots     = '0;
        item_in.base      = '0;
        for (int i = 0; i < bmt_pkg::SLOTS; i++)
        begin
            if (i < MAX_SLOTS)
            begin
                item_in.slots[i] = slots[i*bmt_pkg::SLOT_W +: bmt_pkg::SLOT_W];
                item_in.base[i]  = base_slots[i*bmt_pkg::SLOT_W +: bmt_pkg::SLOT_W];
            end
        end
        item_in.va        = vertex_a;
        item_in.vb        = vertex_b;
        item_in.cnt       = bag_count;
        item_in.mark      = edge_marked;
        item_in.may_close = mode ? (edge_marked & closing_edge) : closing_edge;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

FILE: hdl/bmt_back.sv
// ----------------------------------------------------------------------------
// bmt_back
// Carries out queued items: combinational vertex and edge updates, a two-pass
// slot-by-slot join sequencer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_back #(
    parameter int MAX_SLOTS = 15
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mode,
    input  wire logic               q_valid,
    input  wire bmt_pkg::item_t     q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [59:0]             result_slots,
    output logic                    edge_taken,
    output logic                    last
);

    localparam bmt_pkg::slot_t LIM = bmt_pkg::slot_t'(MAX_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FORK = 4'b0010,
        S_J1   = 4'b0100,
        S_J2   = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    bmt_pkg::sol_t   out_sol_reg, out_sol_next;
    logic            taken_reg, taken_next;
    logic            last_reg, last_next;
    bmt_pkg::sol_t   fork_reg, fork_next;
    bmt_pkg::sol_t   jm_reg, jm_next;
    bmt_pkg::sol_t   jb_reg, jb_next;
    bmt_pkg::slot_t  ji_reg, ji_next;
    bmt_pkg::slot_t  jcnt_reg, jcnt_next;

    bmt_pkg::sol_t   av_res;
    bmt_pkg::sol_t   del_res;
    logic            del_sat;
    bmt_pkg::sol_t   close_res;
    logic            closes;
    bmt_pkg::sol_t   link_res;
    logic            fork_ok;
    bmt_pkg::slot_t  vm, wm;
    logic            out_free;

    // add vertex: open slot at va, renumber partners
    always_comb
    begin
        bmt_pkg::slot_t x;
        av_res = q_item.slots;
        for (int i = 0; i < bmt_pkg::SLOTS; i++)
        begin
            if (i < MAX_SLOTS)
            begin
                if (i > q_item.va && i < q_item.cnt)
                    x = bmt_pkg::slot_rd(q_item.slots, 4'(i-1), LIM);
                else
                    x = q_item.slots[i];
                if (x >= q_item.va && x != bmt_pkg::TWO)
                    x = x + 4'd1;
                if (i == q_item.va)
                    av_res[i] = q_item.va;
                else if (i < q_item.va || (i > q_item.va && i < q_item.cnt))
                    av_res[i] = x;
            end
        end
    end

    // delete vertex: saturated slot drops out, others shift down
    always_comb
    begin
        bmt_pkg::slot_t x;
        del_sat = (bmt_pkg::slot_rd(q_item.slots, q_item.va, LIM) == bmt_pkg::TWO);
        del_res = q_item.slots;
        for (int i = 0; i < bmt_pkg::SLOTS; i++)
        begin
            if (i < MAX_SLOTS)
            begin
                // top position reads zero from beyond the bag
                if (i >= q_item.va)
                    x = bmt_pkg::slot_rd(q_item.slots, 4'(i+1), LIM);
                else
                    x = q_item.slots[i];
                if (x > q_item.va && x != bmt_pkg::TWO)
                    x = x - 4'd1;
                if (i == q_item.cnt)
                    del_res[i] = '0;
                else if (i < q_item.va || i < q_item.cnt)
                    del_res[i] = x;
            end
        end
    end

    // add edge: cycle close check, link and fork decision
    always_comb
    begin
        bmt_pkg::slot_t x;
        closes = 1'b1;
        for (int i = 0; i < bmt_pkg::SLOTS; i++)
        begin
            x = bmt_pkg::slot_rd(q_item.slots, 4'(i), LIM);
            if (i < q_item.cnt)
            begin
                if ((x != bmt_pkg::TWO && i != q_item.va && i != q_item.vb) ||
                    (i == q_item.va && x != q_item.vb) ||
                    (i == q_item.vb && x != q_item.va))
                    closes = 1'b0;
            end
        end
        close_res = bmt_pkg::slot_wr(q_item.slots, q_item.va, bmt_pkg::TWO, LIM);
        close_res = bmt_pkg::slot_wr(close_res, q_item.vb, bmt_pkg::TWO, LIM);
        link_res  = bmt_pkg::slot_link(q_item.slots, q_item.va, q_item.vb, LIM);
        vm        = bmt_pkg::slot_rd(q_item.slots, q_item.va, LIM);
        wm        = bmt_pkg::slot_rd(q_item.slots, q_item.vb, LIM);
        fork_ok   = (vm != bmt_pkg::TWO) && (wm != bmt_pkg::TWO) && (vm != q_item.vb);
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        bmt_pkg::slot_t p;
        bmt_pkg::slot_t im;
        bmt_pkg::slot_t pm;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_sol_next   = out_sol_reg;
        taken_next     = taken_reg;
        last_next      = last_reg;
        fork_next      = fork_reg;
        jm_next        = jm_reg;
        jb_next        = jb_reg;
        ji_next        = ji_reg;
        jcnt_next      = jcnt_reg;
        q_pop          = 1'b0;
        p              = '0;
        im             = '0;
        pm             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        bmt_pkg::OP_ADD_VERTEX:
                        begin
                            out_valid_next = 1'b1;
                            out_sol_next   = av_res;
                            taken_next     = 1'b0;
                            last_next      = 1'b1;
                        end
                        bmt_pkg::OP_ADD_EDGE:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (q_item.may_close && closes)
                            begin
                                out_sol_next = close_res;
                                taken_next   = 1'b1;
                            end
                            else if (mode)
                            begin
                                out_sol_next = q_item.mark ? link_res : q_item.slots;
                                taken_next   = q_item.mark;
                            end
                            else if (fork_ok)
                            begin
                                out_sol_next = q_item.slots;
                                taken_next   = 1'b0;
                                last_next    = 1'b0;
                                fork_next    = link_res;
                                state_next   = S_FORK;
                            end
                            else
                            begin
                                out_sol_next = q_item.slots;
                                taken_next   = 1'b0;
                            end
                        end
                        bmt_pkg::OP_DEL_VERTEX:
                        begin
                            if (del_sat)
                            begin
                                out_valid_next = 1'b1;
                                out_sol_next   = del_res;
                                taken_next     = 1'b0;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            jm_next    = q_item.slots;
                            jb_next    = q_item.base;
                            ji_next    = '0;
                            jcnt_next  = q_item.cnt;
                            state_next = S_J1;
                        end
                    endcase
                end
            end
            S_FORK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sol_next   = fork_reg;
                    taken_next     = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            // first pass: move saturated base slots across, check conflicts
            S_J1:
            begin
                if (ji_reg < jcnt_reg)
                begin
                    if (bmt_pkg::slot_rd(jb_reg, ji_reg, LIM) == bmt_pkg::TWO)
                    begin
                        jb_next = bmt_pkg::slot_wr(jb_reg, ji_reg,
                                      bmt_pkg::slot_rd(jm_reg, ji_reg, LIM), LIM);
                        jm_next = bmt_pkg::slot_wr(jm_reg, ji_reg, bmt_pkg::TWO, LIM);
                    end
                    ji_next = ji_reg + 4'd1;
                    if (bmt_pkg::slot_rd(jm_next, ji_reg, LIM) == bmt_pkg::TWO &&
                        bmt_pkg::slot_rd(jb_next, ji_reg, LIM) != ji_reg)
                        state_next = S_IDLE;
                end
                else
                begin
                    ji_next    = '0;
                    state_next = S_J2;
                end
            end
            // second pass: link base path ends into the solution
            S_J2:
            begin
                if (ji_reg < jcnt_reg)
                begin
                    p       = bmt_pkg::slot_rd(jb_reg, ji_reg, LIM);
                    im      = bmt_pkg::slot_rd(jm_reg, ji_reg, LIM);
                    pm      = bmt_pkg::slot_rd(jm_reg, p, LIM);
                    ji_next = ji_reg + 4'd1;
                    if (p < ji_reg)
                    begin
                        if (im == p || pm == ji_reg)
                            state_next = S_IDLE;
                        else
                            jm_next = bmt_pkg::slot_link(jm_reg, ji_reg, p, LIM);
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sol_next   = jm_reg;
                    taken_next     = 1'b0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sol_reg <= out_sol_next;
        taken_reg   <= taken_next;
        last_reg    <= last_next;
        fork_reg    <= fork_next;
        jm_reg      <= jm_next;
        jb_reg      <= jb_next;
        ji_reg      <= ji_next;
        jcnt_reg    <= jcnt_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_slots = out_sol_reg;
    assign edge_taken   = taken_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: hdl/bag_matching_transition.sv
// ----------------------------------------------------------------------------
// bag_matching_transition
// One transition of the Hamiltonian cycle tree-decomposition DP on a single
// partial solution.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item: op, slots, base_slots,
//   vertex_a, vertex_b, bag_count, closing_edge, edge_marked. Output channel
//   out_valid/out_ready carries result items; last flags the final one.
//   An item gives zero, one or two results (add edge may fork: unchanged
//   solution first, extended one second).
//   cfg_we/cfg_wdata writes marked_edges_mode; write only while idle.
//   Items pass a two-entry queue, then the execution unit. Add vertex, add
//   edge and delete vertex are combinational in the unit, so one item per
//   cycle is sustained while the receiver does not stall; a fork holds the
//   unit in its fork state for the second result. A result passes the queue
//   register and then the output register. Join walks the bag one slot per
//   cycle in two passes; the join sequencer takes no new item until done.
//   Reset clears the queue, the sequencer and the mode register. When the
//   receiver stalls the result is held; the queue keeps taking items until
//   full.
// ----------------------------------------------------------------------------
`default_nettype none

module bag_matching_transition #(
    parameter int MAX_SLOTS = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [59:0] slots,
    input  wire logic [59:0] base_slots,
    input  wire logic [3:0]  vertex_a,
    input  wire logic [3:0]  vertex_b,
    input  wire logic [3:0]  bag_count,
    input  wire logic        closing_edge,
    input  wire logic        edge_marked,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [59:0]      result_slots,
    output logic             edge_taken,
    output logic             last
);

    logic           mode_reg;
    logic           q_valid;
    logic           q_pop;
    bmt_pkg::item_t q_item;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    bmt_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .slots        (slots),
        .base_slots   (base_slots),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .bag_count    (bag_count),
        .closing_edge (closing_edge),
        .edge_marked  (edge_marked),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    bmt_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_slots (result_slots),
        .edge_taken   (edge_taken),
        .last         (last)
    );

endmodule

`default_nettype wire

FILE: hdl/bmt_checker.sv
// ----------------------------------------------------------------------------
// bmt_checker
// Port-level checks on the result channel of the transition block.
// ----------------------------------------------------------------------------
`default_nettype none

module bmt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [59:0] result_slots,
    input wire logic        edge_taken,
    input wire logic        last
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_slots) && $stable(last))
        else $error("stalled result changed");

    // only the unchanged half of a fork is not last
    a_first_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !edge_taken)
        else $error("non-final result carries the edge");

    // second half of a fork follows at once
    a_fork_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && edge_taken && last)
        else $error("fork second result missing");

endmodule

bind bag_matching_transition bmt_checker u_bmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_slots (result_slots),
    .edge_taken   (edge_taken),
    .last         (last)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Bag matching transition testbench
// Drives items through the valid/ready input, predicts each tree-decomposition
// result or takes it from the directed table, and compares every result item in
// order, across idle phases and both settings of the marked-edges mode.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    typedef struct {
        logic [59:0] slots;
        logic        taken;
        logic        last;
    } sol_res_t;

    typedef struct {
        bmt_pkg::op_t op;
        logic [59:0]  slots;
        logic [59:0]  base;
        logic [3:0]   va;
        logic [3:0]   vb;
        logic [3:0]   cnt;
        logic         fin;
        logic         mark;
        int           n_exp;     // -1: use predictor
        logic [59:0]  exp_slots;
        logic         exp_taken;
    } row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  op = '0;
    logic [59:0] slots = '0;
    logic [59:0] base_slots = '0;
    logic [3:0]  vertex_a = '0;
    logic [3:0]  vertex_b = '0;
    logic [3:0]  bag_count = '0;
    logic        closing_edge = 0;
    logic        edge_marked = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [59:0] result_slots;
    logic        edge_taken;
    logic        last;

    sol_res_t    pending[$];
    logic        mode_q = 0;
    int          errors = 0;
    int          cycles = 0;
    int          in_idle = 0;
    int          out_stall = 0;

    bag_matching_transition dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .slots(slots),
        .base_slots(base_slots), .vertex_a(vertex_a), .vertex_b(vertex_b),
        .bag_count(bag_count), .closing_edge(closing_edge),
        .edge_marked(edge_marked), .out_valid(out_valid), .out_ready(out_ready),
        .result_slots(result_slots), .edge_taken(edge_taken), .last(last)
    );

    always #5 clk = ~clk;

    // slot access with out-of-range positions reading 0 and writes dropped
    function automatic logic [3:0] get_slot(logic [3:0] m[16], int i);
        if (i < 0 || i >= 15)
            return 4'd0;
        return m[i];
    endfunction

    function automatic void put_slot(ref logic [3:0] m[16], input int i,
                                     input logic [3:0] v);
        if (i >= 0 && i < 15)
            m[i] = v;
    endfunction

    function automatic void join_ends(ref logic [3:0] m[16], input int v, input int w);
        logic [3:0] vm, wm;
        vm = get_slot(m, v);
        wm = get_slot(m, w);
        if (vm != v) put_slot(m, v, bmt_pkg::TWO);
        if (wm != w) put_slot(m, w, bmt_pkg::TWO);
        put_slot(m, int'(vm), wm);
        put_slot(m, int'(wm), vm);
    endfunction

    function automatic logic [59:0] pack_sol(logic [3:0] m[16]);
        logic [59:0] p;
        p = '0;
        for (int i = 0; i < 15; i++)
            p[4*i +: 4] = m[i];
        return p;
    endfunction

    function automatic void push_res(logic [3:0] m[16], logic t, logic l);
        sol_res_t r;
        r.slots = pack_sol(m);
        r.taken = t;
        r.last = l;
        pending = {pending, r};
    endfunction

    // predict the results of one transition
    function automatic void predict_transition(row_t r);
        logic [3:0] m[16], b[16], n[16];
        logic [3:0] x, vm, wm, im, pm;
        int v, w, c, k, p;
        logic may_close, ok, dropped;
        v = int'(r.va); w = int'(r.vb); c = int'(r.cnt);
        for (int i = 0; i < 16; i++)
        begin
            m[i] = (i < 15) ? r.slots[4*i +: 4] : 4'd0;
            b[i] = (i < 15) ? r.base[4*i +: 4] : 4'd0;
        end
        case (r.op)
            bmt_pkg::OP_ADD_VERTEX:
            begin
                k = c - 1;
                for (int i = k; i > v; i--)
                begin
                    x = get_slot(m, i - 1);
                    if (x >= v && x != bmt_pkg::TWO) x = x + 4'd1;
                    put_slot(m, i, x);
                end
                put_slot(m, v, v[3:0]);
                for (int i = v - 1; i >= 0; i--)
                begin
                    x = get_slot(m, i);
                    if (x >= v && x != bmt_pkg::TWO) put_slot(m, i, x + 4'd1);
                end
                push_res(m, 1'b0, 1'b1);
            end
            bmt_pkg::OP_ADD_EDGE:
            begin
                may_close = mode_q ? (r.mark && r.fin) : r.fin;
                ok = 1;
                for (int i = 0; i < c; i++)
                begin
                    x = get_slot(m, i);
                    if ((x != bmt_pkg::TWO && i != v && i != w) || (i == v && x != w)
                        || (i == w && x != v))
                        ok = 0;
                end
                if (may_close && ok)
                begin
                    put_slot(m, v, bmt_pkg::TWO);
                    put_slot(m, w, bmt_pkg::TWO);
                    push_res(m, 1'b1, 1'b1);
                end
                else if (mode_q)
                begin
                    if (r.mark) join_ends(m, v, w);
                    push_res(m, r.mark, 1'b1);
                end
                else
                begin
                    vm = get_slot(m, v);
                    wm = get_slot(m, w);
                    if (vm != bmt_pkg::TWO && wm != bmt_pkg::TWO && vm != w)
                    begin
                        n = m;
                        join_ends(n, v, w);
                        push_res(m, 1'b0, 1'b0);
                        push_res(n, 1'b1, 1'b1);
                    end
                    else
                        push_res(m, 1'b0, 1'b1);
                end
            end
            bmt_pkg::OP_DEL_VERTEX:
            begin
                k = c - 1;
                if (get_slot(m, v) == bmt_pkg::TWO)
                begin
                    for (int i = 0; i < v; i++)
                    begin
                        x = get_slot(m, i);
                        if (x > v && x != bmt_pkg::TWO) put_slot(m, i, x - 4'd1);
                    end
                    for (int i = v; i <= k; i++)
                    begin
                        x = get_slot(m, i + 1);
                        if (x > v && x != bmt_pkg::TWO) x = x - 4'd1;
                        put_slot(m, i, x);
                    end
                    put_slot(m, k + 1, 4'd0);
                    push_res(m, 1'b0, 1'b1);
                end
            end
            default:
            begin
                dropped = 0;
                for (int i = 0; i < c && !dropped; i++)
                begin
                    if (get_slot(b, i) == bmt_pkg::TWO)
                    begin
                        put_slot(b, i, get_slot(m, i));
                        put_slot(m, i, bmt_pkg::TWO);
                    end
                    if (get_slot(m, i) == bmt_pkg::TWO && get_slot(b, i) != i) dropped = 1;
                end
                for (int i = 0; i < c && !dropped; i++)
                begin
                    p = int'(get_slot(b, i));
                    if (p < i)
                    begin
                        im = get_slot(m, i);
                        pm = get_slot(m, p);
                        if (im == p || pm == i) dropped = 1;
                        else join_ends(m, i, p);
                    end
                end
                if (!dropped) push_res(m, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        sol_res_t e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: slots %h", result_slots);
                errors++;
            end
            else
            begin
                e = pending.pop_front();
                if (result_slots !== e.slots)
                begin
                    $error("result_slots exp %h got %h", e.slots, result_slots);
                    errors++;
                end
                if (edge_taken !== e.taken)
                begin
                    $error("edge_taken exp %0b got %0b", e.taken, edge_taken);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last exp %0b got %0b", e.last, last);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_stall);

    // sender stops, then waits for every result and for dropped items to clear
    task automatic wait_drained();
        in_valid <= 0;
        while (pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_mode(logic val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
        mode_q = val;
    endtask

    // present one item and wait for its acceptance
    task automatic send_item(row_t r);
        if ($urandom_range(99) < in_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < in_idle) @(negedge clk);
        end
        op <= r.op; slots <= r.slots; base_slots <= r.base;
        vertex_a <= r.va; vertex_b <= r.vb; bag_count <= r.cnt;
        closing_edge <= r.fin; edge_marked <= r.mark;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (r.n_exp < 0)
            predict_transition(r);
        else if (r.n_exp > 0)
        begin
            sol_res_t e;
            e.slots = r.exp_slots;
            e.taken = r.exp_taken;
            e.last = 1;
            pending = {pending, e};
        end
        @(negedge clk);
    endtask

    // random well-formed-ish solution: identity, saturated and paired ends
    function automatic logic [59:0] rand_sol(int c);
        logic [3:0] m[16];
        int a, b2;
        for (int i = 0; i < 16; i++) m[i] = (i < c) ? i[3:0] : 4'($urandom_range(15));
        for (int i = 0; i < c; i++)
            if ($urandom_range(3) == 0) m[i] = bmt_pkg::TWO;
        for (int j = 0; j < 3 && c > 1; j++)
        begin
            a = $urandom_range(c - 1);
            b2 = $urandom_range(c - 1);
            if (a != b2 && m[a] == a && m[b2] == b2)
            begin
                m[a] = 4'(b2); m[b2] = 4'(a);
            end
        end
        return pack_sol(m);
    endfunction

    function automatic row_t rand_row();
        row_t r;
        int c;
        c = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
        r.op = bmt_pkg::op_t'(2'($urandom_range(3)));
        r.n_exp = -1;
        r.exp_slots = '0; r.exp_taken = 0;
        if ($urandom_range(9) == 0)
        begin
            r.slots = 60'({$urandom(), $urandom()});
            r.base = 60'({$urandom(), $urandom()});
            r.va = 4'($urandom_range(15));
            r.vb = 4'($urandom_range(15));
        end
        else
        begin
            r.slots = rand_sol(c);
            r.base = rand_sol(c);
            r.va = (c > 0) ? 4'($urandom_range(c - 1)) : 4'd0;
            r.vb = (c > 0) ? 4'($urandom_range(c - 1)) : 4'd0;
        end
        r.cnt = 4'(c);
        r.fin = 1'($urandom_range(1));
        r.mark = 1'($urandom_range(1));
        return r;
    endfunction

    row_t dir[$];

    function automatic row_t mk(bmt_pkg::op_t o, logic [59:0] s, logic [59:0] b, int a,
                                int vb, int c, logic f, logic mk_, int ne,
                                logic [59:0] es, logic et);
        row_t r;
        r.op = o; r.slots = s; r.base = b; r.va = 4'(a); r.vb = 4'(vb); r.cnt = 4'(c);
        r.fin = f; r.mark = mk_; r.n_exp = ne; r.exp_slots = es; r.exp_taken = et;
        return r;
    endfunction

    initial
    begin
        // directed table
        dir = {dir, mk(bmt_pkg::OP_ADD_VERTEX, '0, '0, 0, 0, 1, 0, 0, 1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_VERTEX, '1, '1, 14, 14, 15, 1, 1, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_VERTEX, 60'h0E, '0, 0, 0, 3, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_VERTEX, 60'h210, '0, 0, 0, 0, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, 60'h10, '0, 0, 1, 2, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, 60'h01, '0, 0, 1, 2, 1, 0, 1, 60'hFF, 1)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, 60'hF01, '0, 0, 1, 3, 1, 1, 1, 60'hFFF, 1)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, 60'hF10, '0, 0, 2, 3, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, '1, '1, 14, 14, 15, 1, 1, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_ADD_EDGE, 60'h210, '0, 0, 2, 3, 1, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_DEL_VERTEX, 60'h210, '0, 1, 0, 3, 0, 0, 0, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_DEL_VERTEX, 60'h2F0, '0, 1, 0, 3, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_DEL_VERTEX, 60'h0F, '0, 0, 0, 0, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_DEL_VERTEX, '1, '1, 14, 0, 15, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, 60'h210, 60'h210, 0, 0, 3, 0, 0, 1, 60'h210, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, 60'h01, 60'h01, 0, 0, 2, 0, 0, 0, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, 60'h210, 60'h201, 0, 0, 3, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, 60'hF0, 60'h1F, 0, 0, 2, 0, 0, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, '1, '1, 0, 0, 15, 1, 1, -1, '0, 0)};
        dir = {dir, mk(bmt_pkg::OP_JOIN, '0, '0, 0, 0, 0, 0, 0, 1, '0, 0)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        foreach (dir[i]) send_item(dir[i]);
        wait_drained();
        set_mode(1);
        foreach (dir[i])
            if (dir[i].op == bmt_pkg::OP_ADD_EDGE)
            begin
                row_t r;
                r = dir[i];
                r.n_exp = -1;
                send_item(r);
            end
        wait_drained();

        // random phases: idling pattern and mode change between phases
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    in_idle = 0;  out_stall = 0;
                end
                1:
                begin
                    in_idle = 48; out_stall = 0;
                end
                2:
                begin
                    in_idle = 0;  out_stall = 48;
                end
                default:
                begin
                    in_idle = 34; out_stall = 34;
                end
            endcase
            set_mode(ph[0]);
            for (int j = 0; j < 80; j++)
            begin
                send_item(rand_row());
                if (j == 40) wait_drained();
            end
            wait_drained();
        end
        set_mode(0);
        for (int j = 0; j < 10; j++) send_item(rand_row());
        wait_drained();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // timeout guard
    always @(posedge clk)
        if (cycles >= LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
endmodule
